/* hdl/byte_stream_reassembler_assert.svh */
// Assertion macros for the reassembler datapath (bsr_dp).
// The enclosing module must provide clk and rst_n.
`ifndef BYTE_STREAM_REASSEMBLER_ASSERT_SVH
`define BYTE_STREAM_REASSEMBLER_ASSERT_SVH

`ifndef SYNTH
`define BSR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte_stream_reassembler: same-cycle check failed");
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte_stream_reassembler: next-cycle check failed");
`else
`define BSR_ASSERT_SAME(lbl, ante, cons)
`define BSR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/bsr_pkg.sv */
package bsr_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int OFF_W        = 32;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 7;
  localparam int WIN_W        = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic read;
    logic emit_byte;
    logic emit_status;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

/* hdl/bsr_ifs.sv */
interface bsr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          has_byte;
  logic [bsr_pkg::BYTE_W-1:0]    data_byte;
  logic [bsr_pkg::OFF_W-1:0]     stream_offset;
  logic                          end_of_stream;

  modport source (output valid, has_byte, data_byte, stream_offset, end_of_stream,
                  input ready);
  modport sink   (input valid, has_byte, data_byte, stream_offset, end_of_stream,
                  output ready);
endinterface

interface bsr_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsr_pkg::BYTE_W-1:0]    out_byte;
  logic                          byte_valid;
  logic [bsr_pkg::CNT_W-1:0]     pending_count;
  logic                          stream_ended;
  logic                          last;

  modport source (output valid, out_byte, byte_valid, pending_count, stream_ended, last,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, pending_count, stream_ended, last,
                  output ready);
endinterface

interface bsr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bsr_pkg::WIN_W-1:0]     window_size;

  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface

/* hdl/bsr_ctrl.sv */
module bsr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsr_pkg::sts_t sts_i,
  output bsr_pkg::cmd_t cmd_o
);

  bsr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bsr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.latch = 1'b1;
          state_nxt   = bsr_pkg::ST_EVAL;
        end
      end
      bsr_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_nxt  = bsr_pkg::ST_READ;
      end
      bsr_pkg::ST_READ: begin
        // A miss here only happens before the first byte of an item, so it
        // always means a status result.
        if (sts_i.hit) begin
          cmd_o.read = 1'b1;
          state_nxt  = bsr_pkg::ST_EMIT;
        end else if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_nxt         = bsr_pkg::ST_IDLE;
        end
      end
      bsr_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          state_nxt       = sts_i.last ? bsr_pkg::ST_IDLE : bsr_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = bsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/bsr_dp.sv */
`include "byte_stream_reassembler_assert.svh"

module bsr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsr_pkg::cmd_t                cmd_i,
  output bsr_pkg::sts_t                sts_o,
  input  logic                         in_has_byte,
  input  logic [bsr_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [bsr_pkg::OFF_W-1:0]    in_stream_offset,
  input  logic                         in_end_of_stream,
  input  logic                         cfg_we,
  input  logic [bsr_pkg::WIN_W-1:0]    cfg_window_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsr_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_byte_valid,
  output logic [bsr_pkg::CNT_W-1:0]    out_pending_count,
  output logic                         out_stream_ended,
  output logic                         out_last
);

  localparam int DEPTH = bsr_pkg::WINDOW_DEPTH;
  localparam int IW    = bsr_pkg::IDX_W;
  localparam int OW    = bsr_pkg::OFF_W;
  localparam int CW    = bsr_pkg::CNT_W;
  localparam int WW    = bsr_pkg::WIN_W;

  // Latched input item
  logic                        has_r;
  logic [bsr_pkg::BYTE_W-1:0]  data_r;
  logic [OW-1:0]               off_r;
  logic                        eof_r;

  // Stream state
  logic [WW-1:0]               window_r;
  logic [OW-1:0]               next_exp_r;
  logic [IW-1:0]               head_r;
  logic [CW-1:0]               pending_r, pending_nxt;
  logic                        eof_seen_r;
  logic [DEPTH-1:0]            present_r;
  logic [bsr_pkg::BYTE_W-1:0]  store_mem [DEPTH];
  logic [bsr_pkg::BYTE_W-1:0]  rdata_r;
  logic                        last_r;

  // Output register
  logic                        out_valid_r;
  logic [bsr_pkg::BYTE_W-1:0]  out_byte_r;
  logic                        out_byte_valid_r;
  logic [CW-1:0]               out_pending_r;
  logic                        out_ended_r;
  logic                        out_last_r;

  logic [WW-1:0]               eff_win;
  logic [OW-1:0]               off_delta;
  logic                        behind;
  logic                        in_win;
  logic [IW:0]                 slot_sum;
  logic [IW-1:0]               slot;
  logic                        store_we;
  logic [IW-1:0]               head_inc;
  logic                        out_free;

  always_comb begin
    eff_win   = (window_r > WW'(DEPTH)) ? WW'(DEPTH) : window_r;
    off_delta = off_r - next_exp_r;
    behind    = off_delta[OW-1];
    in_win    = !behind && (off_delta < OW'(eff_win));
    // off_delta is below DEPTH whenever the slot is used, so one subtract wraps it.
    slot_sum = {1'b0, head_r} + {1'b0, off_delta[IW-1:0]};
    slot     = (slot_sum >= (IW+1)'(DEPTH)) ? IW'(slot_sum - (IW+1)'(DEPTH))
                                            : slot_sum[IW-1:0];
    store_we = cmd_i.eval && has_r && in_win && !present_r[slot];
    head_inc = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);
    out_free = !out_valid_r || out_ready;

    pending_nxt = pending_r;
    if (store_we) begin
      pending_nxt = pending_r + CW'(1);
    end else if (cmd_i.read && (pending_r != '0)) begin
      pending_nxt = pending_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      has_r  <= in_has_byte;
      data_r <= in_data_byte;
      off_r  <= in_stream_offset;
      eof_r  <= in_end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[slot] <= data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.read) begin
      rdata_r <= store_mem[head_r];
      // The bit at the following slot decides whether the run continues.
      last_r  <= !present_r[head_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= bsr_pkg::WIN_RESET;
      next_exp_r  <= '0;
      head_r      <= '0;
      pending_r   <= '0;
      eof_seen_r  <= 1'b0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      if (cfg_we) begin
        window_r <= cfg_window_size;
      end
      if (cmd_i.eval && (behind || in_win) && eof_r) begin
        eof_seen_r <= 1'b1;
      end
      if (store_we) begin
        present_r[slot] <= 1'b1;
      end
      if (cmd_i.read) begin
        present_r[head_r] <= 1'b0;
        head_r            <= head_inc;
        next_exp_r        <= next_exp_r + OW'(1);
      end
      if (cmd_i.emit_byte || cmd_i.emit_status) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit_byte) begin
      out_byte_r       <= rdata_r;
      out_byte_valid_r <= 1'b1;
      out_pending_r    <= pending_r;
      out_ended_r      <= eof_seen_r && (pending_r == '0);
      out_last_r       <= last_r;
    end else if (cmd_i.emit_status) begin
      out_byte_r       <= '0;
      out_byte_valid_r <= 1'b0;
      out_pending_r    <= pending_r;
      out_ended_r      <= eof_seen_r && (pending_r == '0);
      out_last_r       <= 1'b1;
    end
  end

  assign sts_o.hit      = present_r[head_r];
  assign sts_o.last     = last_r;
  assign sts_o.out_free = out_free;

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_byte_valid    = out_byte_valid_r;
  assign out_pending_count = out_pending_r;
  assign out_stream_ended  = out_ended_r;
  assign out_last          = out_last_r;

  `BSR_ASSERT_SAME(a_pending_matches_map, 1'b1, pending_r == $countones(present_r))
  `BSR_ASSERT_NEXT(a_read_clears_head, cmd_i.read, !present_r[$past(head_r)])
  `BSR_ASSERT_SAME(a_emit_needs_room, cmd_i.emit_byte || cmd_i.emit_status, out_free)

endmodule

/* hdl/byte_stream_reassembler.sv */
// Reassembles a byte stream from items tagged with absolute 32-bit offsets. Each
// transfer on the input carries at most one byte; bytes inside the receive window
// (next expected offset plus min(window_size, WINDOW_DEPTH)) land in a ring store
// with a present bit per slot, bytes already delivered are dropped, and bytes past
// the window are ignored together with their end-of-stream mark. Every input item
// yields either the contiguous in-order run that became available, one result per
// byte with last on the final one, or a single status result with byte_valid low.
// An item's offset is checked and the store written after its input transfer; then
// a status result is loaded into the output register, or each delivered byte costs
// a registered read of the single-port store and a load of the output register,
// which stalls while it is full. The next item is taken once the last result of the
// current one is in the output register. window_size is written through the cfg
// channel, which is always ready; write it only while no item is in flight.
module byte_stream_reassembler (
  input  logic       clk,
  input  logic       rst_n,
  bsr_in_if.sink     in_ch,
  bsr_out_if.source  out_ch,
  bsr_cfg_if.sink    cfg_ch
);

  bsr_pkg::cmd_t cmd;
  bsr_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  bsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  bsr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_has_byte       (in_ch.has_byte),
    .in_data_byte      (in_ch.data_byte),
    .in_stream_offset  (in_ch.stream_offset),
    .in_end_of_stream  (in_ch.end_of_stream),
    .cfg_we            (cfg_ch.valid),
    .cfg_window_size   (cfg_ch.window_size),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_byte          (out_ch.out_byte),
    .out_byte_valid    (out_ch.byte_valid),
    .out_pending_count (out_ch.pending_count),
    .out_stream_ended  (out_ch.stream_ended),
    .out_last          (out_ch.last)
  );

endmodule

/* tb/byte_stream_reassembler_tb.sv */
module byte_stream_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bsr_pkg::BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                       has_byte;
    logic [bsr_pkg::BYTE_W-1:0] data_byte;
    logic [bsr_pkg::OFF_W-1:0]  stream_offset;
    logic                       end_of_stream;
  } stream_item_t;

  typedef struct packed {
    logic [bsr_pkg::BYTE_W-1:0] out_byte;
    logic                       byte_valid;
    logic [bsr_pkg::CNT_W-1:0]  pending_count;
    logic                       stream_ended;
    logic                       last;
  } stream_result_t;

  typedef struct packed {
    logic           typed_res;
    stream_item_t   item;
    stream_result_t res;
  } script_row_t;

  typedef enum int {ORDER_FWD, ORDER_REV, ORDER_MIX} seg_order_t;
  typedef enum int {NOISE_BEHIND, NOISE_BEYOND, NOISE_ANY, NOISE_MARKER} noise_kind_t;

  localparam int NUM_ROWS    = 14;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_PHASE  = 4;
  localparam int PAUSE_PHASE = 3;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 6;

  // Rows with typed_res set carry the single status result that must come back.
  localparam script_row_t SCRIPT [NUM_ROWS] = '{
    '{1'b1, '{1'b0, 8'h00, 32'h0000_0000, 1'b0}, '{8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
    '{1'b1, '{1'b1, 8'hFF, 32'h0000_0001, 1'b0}, '{8'h00, 1'b0, 7'd1, 1'b0, 1'b1}},
    '{1'b1, '{1'b1, 8'hA5, 32'h0000_0001, 1'b0}, '{8'h00, 1'b0, 7'd1, 1'b0, 1'b1}},
    '{1'b1, '{1'b1, 8'h00, 32'h0000_003F, 1'b0}, '{8'h00, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{1'b1, '{1'b1, 8'h77, 32'h0000_0040, 1'b1}, '{8'h00, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{1'b1, '{1'b1, 8'h11, 32'hFFFF_FFFF, 1'b0}, '{8'h00, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{1'b1, '{1'b0, 8'h00, 32'h8000_0000, 1'b0}, '{8'h00, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{1'b1, '{1'b1, 8'h33, 32'h7FFF_FFFF, 1'b0}, '{8'h00, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{1'b0, '{1'b1, 8'h5A, 32'h0000_0000, 1'b0}, '0},
    '{1'b0, '{1'b1, 8'hC3, 32'h0000_0004, 1'b0}, '0},
    '{1'b0, '{1'b1, 8'h3C, 32'h0000_0003, 1'b0}, '0},
    '{1'b0, '{1'b1, 8'h81, 32'h0000_0002, 1'b0}, '0},
    '{1'b0, '{1'b0, 8'h00, 32'h0000_0001, 1'b1}, '0},
    '{1'b0, '{1'b1, 8'h22, 32'h0000_0001, 1'b0}, '0}
  };

  localparam logic [bsr_pkg::WIN_W-1:0] PHASE_WIN [NUM_PHASES] =
    '{7'd1, 7'd127, 7'd0, 7'd9, 7'd64, 7'd33, 7'd2, 7'd64};
  localparam int PHASE_BUDGET [NUM_PHASES] = '{20, 36, 8, 28, 44, 32, 20, 44};

  logic clk;
  logic rst_n;

  bsr_in_if  in_ch ();
  bsr_out_if out_ch ();
  bsr_cfg_if cfg_ch ();

  byte_stream_reassembler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Own copy of the reassembly state.
  logic [bsr_pkg::BYTE_W-1:0]       byte_mem [bsr_pkg::WINDOW_DEPTH];
  logic [bsr_pkg::WINDOW_DEPTH-1:0] held_map   = '0;
  logic [bsr_pkg::OFF_W-1:0]        next_off   = '0;
  int unsigned                      held_cnt   = 0;
  bit                               eof_mark   = 1'b0;
  int unsigned                      head       = 0;
  logic [bsr_pkg::WIN_W-1:0]        window_reg = bsr_pkg::WIN_RESET;
  bit                               item_ignored;

  stream_result_t run_q [$];
  stream_result_t due_q [$];
  stream_result_t want;

  int  mismatches  = 0;
  int  taken_items = 0;
  bit  tx_idle     = 1'b1;
  bit  rx_idle     = 1'b1;
  bit  hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // Fills run_q with the results that one accepted item causes.
  function automatic void reassemble_item(input stream_item_t it);
    int unsigned               win;
    int unsigned               slot;
    logic [bsr_pkg::OFF_W-1:0] off_delta;
    bit                        behind;
    stream_result_t            r;
    run_q.delete();
    win = (window_reg > bsr_pkg::WINDOW_DEPTH) ? bsr_pkg::WINDOW_DEPTH : window_reg;
    off_delta = it.stream_offset - next_off;
    behind = off_delta[bsr_pkg::OFF_W-1];
    item_ignored = !(behind || off_delta < win);
    if (!item_ignored) begin
      if (it.end_of_stream) eof_mark = 1'b1;
      if (it.has_byte && !behind) begin
        slot = (head + off_delta) % bsr_pkg::WINDOW_DEPTH;
        if (!held_map[slot]) begin
          held_map[slot] = 1'b1;
          byte_mem[slot] = it.data_byte;
          held_cnt++;
        end
      end
    end
    while (run_q.size() < bsr_pkg::WINDOW_DEPTH && held_map[head]) begin
      r.out_byte = byte_mem[head];
      held_map[head] = 1'b0;
      head = (head + 1) % bsr_pkg::WINDOW_DEPTH;
      next_off++;
      if (held_cnt > 0) held_cnt--;
      r.byte_valid = 1'b1;
      r.pending_count = held_cnt[bsr_pkg::CNT_W-1:0];
      r.stream_ended = eof_mark && held_cnt == 0;
      r.last = !held_map[head] || run_q.size() + 1 >= bsr_pkg::WINDOW_DEPTH;
      run_q.push_back(r);
    end
    if (run_q.size() == 0) begin
      r.out_byte = '0;
      r.byte_valid = 1'b0;
      r.pending_count = held_cnt[bsr_pkg::CNT_W-1:0];
      r.stream_ended = eof_mark && held_cnt == 0;
      r.last = 1'b1;
      run_q.push_back(r);
    end
  endfunction

  task automatic send_item(input stream_item_t it, input bit use_typed,
                           input stream_result_t typed_res);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.has_byte      <= it.has_byte;
    in_ch.data_byte     <= it.data_byte;
    in_ch.stream_offset <= it.stream_offset;
    in_ch.end_of_stream <= it.end_of_stream;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    reassemble_item(it);
    if (!item_ignored) taken_items++;
    if (use_typed) begin
      due_q.push_back(typed_res);
    end else begin
      foreach (run_q[k]) due_q.push_back(run_q[k]);
    end
  endtask

  function automatic void check_field(input string what, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got byte %0h valid %0b",
                 $time, out_ch.out_byte, out_ch.byte_valid);
      end else begin
        want = due_q.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
        check_field("byte_valid", 32'(want.byte_valid), 32'(out_ch.byte_valid));
        check_field("pending_count", 32'(want.pending_count),
                    32'(out_ch.pending_count));
        check_field("stream_ended", 32'(want.stream_ended), 32'(out_ch.stream_ended));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // Result side: a random stall before each transfer when rx_idle is set, and one long hold on request.
  initial begin : rx_side
    int unsigned stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_idle ? $urandom_range(0, 16) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    stream_item_t   it;
    stream_result_t none_res;
    seg_order_t     seg_order;
    noise_kind_t    noise;
    int             seg_pos [$];
    int             len;
    int             budget;
    int             sent;
    int unsigned    gen_win;
    logic [31:0]    seg_start;
    bit             seg_eof;
    bit             paused;

    none_res = '0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.has_byte <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.stream_offset <= '0;
    in_ch.end_of_stream <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.window_size <= bsr_pkg::WIN_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++)
      send_item(SCRIPT[r].item, SCRIPT[r].typed_res, SCRIPT[r].res);
    in_ch.valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // The window only changes while nothing is in flight; held bytes stay.
      while (due_q.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.window_size <= PHASE_WIN[p];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      cfg_ch.valid <= 1'b0;
      window_reg = PHASE_WIN[p];

      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      budget = PHASE_BUDGET[p];
      taken_items = 0;
      sent = 0;
      paused = 1'b0;

      while (taken_items < budget && sent < 4 * budget) begin
        gen_win = (window_reg > bsr_pkg::WINDOW_DEPTH) ? bsr_pkg::WINDOW_DEPTH : window_reg;
        if (gen_win == 0) gen_win = 1;
        if ($urandom_range(0, 9) < 7) begin
          // A segment starting at or a little past the next expected offset.
          len = ($urandom_range(0, 7) == 0) ? gen_win
              : $urandom_range(1, (gen_win < 12) ? gen_win : 12);
          seg_start = next_off +
                      (($urandom_range(0, 3) == 0) ? $urandom_range(0, gen_win - 1) : 0);
          seg_order = seg_order_t'($urandom_range(0, 2));
          seg_eof = ($urandom_range(0, 9) == 0);
          seg_pos.delete();
          for (int k = 0; k < len; k++) begin
            if (seg_order == ORDER_REV) seg_pos.push_front(k);
            else seg_pos.push_back(k);
          end
          if (seg_order == ORDER_MIX) seg_pos.shuffle();
          for (int k = 0; k < len; k++) begin
            it.has_byte = 1'b1;
            it.data_byte = byte_t'($urandom);
            it.stream_offset = seg_start + seg_pos[k];
            it.end_of_stream = seg_eof && (seg_pos[k] == len - 1);
            send_item(it, 1'b0, none_res);
            sent++;
            if ($urandom_range(0, 7) == 0) begin
              it.data_byte = ~it.data_byte;
              it.end_of_stream = 1'b0;
              send_item(it, 1'b0, none_res);
              sent++;
            end
          end
        end else begin
          noise = noise_kind_t'($urandom_range(0, 3));
          it.has_byte = ($urandom_range(0, 1) != 0);
          it.data_byte = byte_t'($urandom);
          it.end_of_stream = ($urandom_range(0, 3) == 0);
          case (noise)
            NOISE_BEHIND: it.stream_offset = next_off - $urandom_range(1, 32'h8000_0000);
            NOISE_BEYOND: it.stream_offset = next_off + gen_win +
                                             $urandom_range(0, 32'h7FFF_FFFF - gen_win);
            NOISE_ANY:    it.stream_offset = $urandom;
            default: begin
              it.has_byte = 1'b0;
              it.end_of_stream = ($urandom_range(0, 1) != 0);
              it.stream_offset = next_off + $urandom_range(0, gen_win);
            end
          endcase
          send_item(it, 1'b0, none_res);
          sent++;
        end
        if (p == PAUSE_PHASE && !paused && taken_items >= budget / 2) begin
          // Hold the input until every result of the earlier items has come out.
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (due_q.size() != 0);
          paused = 1'b1;
        end
      end
      in_ch.valid <= 1'b0;
    end

    while (due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* byte_stream_reassembler.f */
+incdir+hdl
hdl/bsr_pkg.sv
hdl/bsr_ifs.sv
hdl/bsr_ctrl.sv
hdl/bsr_dp.sv
hdl/byte_stream_reassembler.sv
tb/byte_stream_reassembler_tb.sv
